FILE: src/ppt_pkg.sv
// Shared types, register indexes and codes of the particle pool tick update.
// No dependencies; every other file of the block but ppt_ram imports it.
package ppt_pkg;

   localparam int SLOT_W     = 6;
   localparam int COUNT_W    = 7;
   localparam int POS_W      = 24;
   localparam int VEL_W      = 16;
   localparam int AGE_W      = 20;
   localparam int DT_W       = 16;
   localparam int LAUNCH_W   = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int MAX_SPEED  = 2;
   localparam int MODE_BIAS  = 10;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_EMITTER_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EMITTER_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EMITTER_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EMITTER_LIFE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PARTICLE_LIFE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MOTION_MODE   = 3'd6;

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic [1:0] MODE_SPARK = 2'd0;
   localparam logic [1:0] MODE_WATER = 2'd1;
   localparam logic [1:0] MODE_SMOKE = 2'd2;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] vel_z;
      logic [AGE_W-1:0]        age;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   typedef struct packed {
      logic              vld;
      logic              last;
      logic [SLOT_W-1:0] idx;
   } lane_type;

   typedef struct packed {
      logic [DT_W-1:0]  dt;
      logic [1:0]       mode;
      logic [AGE_W-1:0] plife;
   } tick_ctl_type;

   typedef struct packed {
      lane_type lane;
      logic     retire;
      slot_type old_slot;
      slot_type new_slot;
   } stage_out_type;

   // launch component: clamp to +-(MAX_SPEED-1) whole units, scale to 1/256
   function automatic logic signed [VEL_W-1:0] launch_vel(
      input logic signed [LAUNCH_W-1:0] raw
   );
      logic signed [VEL_W-1:0] v;
      logic signed [VEL_W-1:0] lim;
      v   = VEL_W'(raw);
      lim = VEL_W'(MAX_SPEED - 1);
      if (v > lim) begin
         v = lim;
      end else if (v < -lim) begin
         v = -lim;
      end
      return v <<< 8;
   endfunction

endpackage

FILE: src/particle_pool_tick_update.sv
// Top level of the particle pool tick update: configuration, slot sweep,
// valid bits, spawn and writeback, result register. Uses ppt_pkg, ppt_ram,
// ppt_slot_pipe.
//
//   channel | direction | handshake          | word
//   req_    | in        | req_valid/ready    | operation, delta_time, spawn, launch xyz
//   rsp_    | out       | rsp_valid/ready    | slot index, live, position, flags
//   csr_    | in        | csr_we             | register index, write data
//
// A tick reads one slot from the slot RAM per cycle while the result register
// is not stalled and passes it through four pipeline stages to writeback and
// the result register. The next word is taken once the last slot of the tick
// has been written back. Active count 0 gives no result.
// Reset is synchronous and frees every slot; the RAM needs no clearing.
// A stalled result register stalls the whole slot pipeline.
module particle_pool_tick_update
   import ppt_pkg::*;
#(
   parameter int POOL_SIZE = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [DT_W-1:0]              req_delta_time,
   input  logic                         req_spawn_request,
   input  logic signed [LAUNCH_W-1:0]   req_launch_x,
   input  logic signed [LAUNCH_W-1:0]   req_launch_y,
   input  logic signed [LAUNCH_W-1:0]   req_launch_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [SLOT_W-1:0]            rsp_slot_index,
   output logic                         rsp_slot_live,
   output logic signed [POS_W-1:0]      rsp_out_x,
   output logic signed [POS_W-1:0]      rsp_out_y,
   output logic signed [POS_W-1:0]      rsp_out_z,
   output logic                         rsp_emitter_alive,
   output logic                         rsp_last_of_tick,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

   // configuration
   logic signed [POS_W-1:0] ex_ff, ey_ff, ez_ff;
   logic [COUNT_W-1:0]      count_ff;
   logic [AGE_W-1:0]        elife_ff, plife_ff;
   logic [1:0]              mode_ff;

   // tick control
   logic                    busy_ff, busy_in;
   logic                    restart_ff;
   logic                    spawn_pend_ff, spawn_pend_in;
   logic [DT_W-1:0]         dt_ff;
   logic signed [VEL_W-1:0] lvx_ff, lvy_ff, lvz_ff;
   logic [AGE_W-1:0]        eage_ff, eage_in;
   logic [AGE_W:0]          eage_sum;
   logic [COUNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic [COUNT_W-1:0]      n_use;
   lane_type                s1_lane_ff, s1_lane_in;
   logic [POOL_SIZE-1:0]    valid_ff, valid_in;

   logic adv, accept, issue;

   // RAM and pipeline
   slot_type      rd_slot, wr_slot;
   logic          wr_en;
   stage_out_type pout;
   tick_ctl_type  tick;

   // writeback decisions
   logic                    live_old, live_new, do_spawn;
   logic signed [POS_W-1:0] rep_x, rep_y, rep_z;

   // result register
   logic                    rsp_valid_ff;
   logic [SLOT_W-1:0]       rsp_idx_ff;
   logic                    rsp_live_ff, rsp_alive_ff, rsp_last_ff;
   logic signed [POS_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;

   assign adv    = !rsp_valid_ff || rsp_ready;
   assign n_use  = (count_ff > COUNT_W'(POOL_SIZE)) ? COUNT_W'(POOL_SIZE) : count_ff;
   assign accept = req_valid && !busy_ff;
   assign issue  = busy_ff && (rd_cnt_ff < n_use) && adv;

   assign req_ready = !busy_ff;

   assign tick.dt    = dt_ff;
   assign tick.mode  = mode_ff;
   assign tick.plife = plife_ff;

   ppt_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (POOL_SIZE)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pout.lane.idx[IDX_W-1:0]),
      .wr_data (wr_slot),
      .rd_en   (issue),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_slot)
   );

   ppt_slot_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .lane_in   (s1_lane_ff),
      .slot_in   (rd_slot),
      .tick      (tick),
      .stage_out (pout)
   );

   // sweep control
   always_comb begin
      busy_in    = busy_ff;
      rd_cnt_in  = rd_cnt_ff;
      eage_sum   = {1'b0, eage_ff} + (AGE_W+1)'(req_delta_time);
      eage_in    = eage_ff;
      s1_lane_in = s1_lane_ff;
      if (accept) begin
         busy_in   = (n_use != '0);
         rd_cnt_in = '0;
         if (req_operation == OP_RESTART) begin
            eage_in = '0;
         end else begin
            eage_in = eage_sum[AGE_W] ? {AGE_W{1'b1}} : eage_sum[AGE_W-1:0];
         end
      end
      if (issue) begin
         rd_cnt_in = rd_cnt_ff + 1'b1;
      end
      if (adv) begin
         s1_lane_in.vld  = issue;
         s1_lane_in.idx  = rd_cnt_ff[SLOT_W-1:0];
         s1_lane_in.last = (rd_cnt_ff == n_use - 1'b1);
         if (pout.lane.vld && pout.lane.last) begin
            busy_in = 1'b0;
         end
      end
   end

   // writeback: update, retire, spawn into the first free slot
   always_comb begin
      live_old      = valid_ff[pout.lane.idx[IDX_W-1:0]];
      live_new      = live_old;
      do_spawn      = 1'b0;
      wr_en         = 1'b0;
      wr_slot       = pout.new_slot;
      spawn_pend_in = spawn_pend_ff;
      valid_in      = valid_ff;
      rep_x         = pout.old_slot.pos_x;
      rep_y         = pout.old_slot.pos_y;
      rep_z         = pout.old_slot.pos_z;
      if (pout.lane.vld && !restart_ff) begin
         if (live_old) begin
            wr_en    = 1'b1;
            live_new = !pout.retire;
            rep_x    = pout.new_slot.pos_x;
            rep_y    = pout.new_slot.pos_y;
            rep_z    = pout.new_slot.pos_z;
         end
         if (!live_new && spawn_pend_ff) begin
            do_spawn = 1'b1;
         end
      end
      if (do_spawn) begin
         wr_en         = 1'b1;
         live_new      = 1'b1;
         spawn_pend_in = 1'b0;
         wr_slot.pos_x = ex_ff;
         wr_slot.pos_y = ey_ff;
         wr_slot.pos_z = ez_ff;
         wr_slot.vel_x = lvx_ff;
         wr_slot.vel_y = lvy_ff;
         wr_slot.vel_z = lvz_ff;
         wr_slot.age   = '0;
         rep_x         = ex_ff;
         rep_y         = ey_ff;
         rep_z         = ez_ff;
      end
      if (!adv) begin
         wr_en         = 1'b0;
         spawn_pend_in = spawn_pend_ff;
      end else if (pout.lane.vld) begin
         valid_in[pout.lane.idx[IDX_W-1:0]] = live_new;
      end
      if (accept) begin
         spawn_pend_in = req_spawn_request && (req_operation == OP_TICK);
      end
      // shrinking the pool frees every slot at or past the new count
      if (csr_we && csr_index == REG_ACTIVE_COUNT) begin
         for (int i = 0; i < POOL_SIZE; i++) begin
            if (COUNT_W'(i) >= csr_wdata[COUNT_W-1:0]) begin
               valid_in[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_ff         <= '0;
         ey_ff         <= '0;
         ez_ff         <= '0;
         count_ff      <= COUNT_W'(1);
         elife_ff      <= '0;
         plife_ff      <= '0;
         mode_ff       <= MODE_SPARK;
         busy_ff       <= 1'b0;
         spawn_pend_ff <= 1'b0;
         eage_ff       <= '0;
         rd_cnt_ff     <= '0;
         s1_lane_ff    <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_EMITTER_X:     ex_ff    <= csr_wdata[POS_W-1:0];
               REG_EMITTER_Y:     ey_ff    <= csr_wdata[POS_W-1:0];
               REG_EMITTER_Z:     ez_ff    <= csr_wdata[POS_W-1:0];
               REG_ACTIVE_COUNT:  count_ff <= csr_wdata[COUNT_W-1:0];
               REG_EMITTER_LIFE:  elife_ff <= csr_wdata[AGE_W-1:0];
               REG_PARTICLE_LIFE: plife_ff <= csr_wdata[AGE_W-1:0];
               REG_MOTION_MODE:   mode_ff  <= csr_wdata[1:0];
               default: ;
            endcase
         end
         busy_ff       <= busy_in;
         spawn_pend_ff <= spawn_pend_in;
         eage_ff       <= eage_in;
         rd_cnt_ff     <= rd_cnt_in;
         s1_lane_ff    <= s1_lane_in;
         valid_ff      <= valid_in;
         if (adv) begin
            rsp_valid_ff <= pout.lane.vld;
         end
      end
   end

   // word registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         restart_ff <= (req_operation == OP_RESTART);
         dt_ff      <= req_delta_time;
         lvx_ff     <= launch_vel(req_launch_x);
         lvy_ff     <= launch_vel(req_launch_y);
         lvz_ff     <= launch_vel(req_launch_z);
      end
      if (adv) begin
         rsp_idx_ff   <= pout.lane.idx;
         rsp_live_ff  <= live_new;
         rsp_x_ff     <= live_new ? rep_x : '0;
         rsp_y_ff     <= live_new ? rep_y : '0;
         rsp_z_ff     <= live_new ? rep_z : '0;
         rsp_alive_ff <= (eage_ff <= elife_ff);
         rsp_last_ff  <= pout.lane.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_index    = rsp_idx_ff;
   assign rsp_slot_live     = rsp_live_ff;
   assign rsp_out_x         = rsp_x_ff;
   assign rsp_out_y         = rsp_y_ff;
   assign rsp_out_z         = rsp_z_ff;
   assign rsp_emitter_alive = rsp_alive_ff;
   assign rsp_last_of_tick  = rsp_last_ff;

endmodule

FILE: src/ppt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ppt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ppt_slot_pipe.sv
// Slot update pipeline: velocity bias and aging, then the three position
// multiplies, rounding and the saturating position add. Uses ppt_pkg.
module ppt_slot_pipe
   import ppt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  lane_type      lane_in,
   input  slot_type      slot_in,
   input  tick_ctl_type  tick,
   output stage_out_type stage_out
);

   lane_type                s2_lane_ff, s3_lane_ff, s4_lane_ff;
   slot_type                s2_slot_ff, s3_slot_ff, s4_slot_ff;
   logic signed [VEL_W-1:0] s2_vely_ff, s3_vely_ff, s4_vely_ff;
   logic [AGE_W-1:0]        s2_age_ff, s3_age_ff, s4_age_ff;
   logic                    s3_retire_ff, s4_retire_ff;
   logic signed [32:0]      s3_px_ff, s3_py_ff, s3_pz_ff;
   logic signed [21:0]      s4_sx_ff, s4_sy_ff, s4_sz_ff;

   logic signed [VEL_W:0]   vy_sum;
   logic signed [VEL_W-1:0] vely_in;
   logic [AGE_W:0]          age_sum;
   logic [AGE_W-1:0]        age_in;
   logic signed [DT_W:0]    dt_s;
   logic signed [33:0]      rx, ry, rz;
   logic signed [POS_W-1:0] nx, ny, nz;

   function automatic logic signed [POS_W-1:0] pos_step(
      input logic signed [POS_W-1:0] pos,
      input logic signed [21:0]      step
   );
      logic signed [POS_W:0] s;
      s = {pos[POS_W-1], pos} + {{(POS_W-21){step[21]}}, step};
      if (s[POS_W] != s[POS_W-1]) begin
         return s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end
      return s[POS_W-1:0];
   endfunction

   // stage 1: bias on y velocity, saturating age
   always_comb begin
      case (tick.mode)
         MODE_WATER: vy_sum = {slot_in.vel_y[VEL_W-1], slot_in.vel_y} - (VEL_W+1)'(MODE_BIAS);
         MODE_SMOKE: vy_sum = {slot_in.vel_y[VEL_W-1], slot_in.vel_y} + (VEL_W+1)'(MODE_BIAS);
         default:    vy_sum = {slot_in.vel_y[VEL_W-1], slot_in.vel_y};
      endcase
      if (vy_sum[VEL_W] != vy_sum[VEL_W-1]) begin
         vely_in = vy_sum[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
      end else begin
         vely_in = vy_sum[VEL_W-1:0];
      end
      age_sum = {1'b0, slot_in.age} + (AGE_W+1)'(tick.dt);
      age_in  = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];
   end

   assign dt_s = $signed({1'b0, tick.dt});

   // stage 3 rounding: floor((p + 2048) / 4096)
   assign rx = {s3_px_ff[32], s3_px_ff} + 34'sd2048;
   assign ry = {s3_py_ff[32], s3_py_ff} + 34'sd2048;
   assign rz = {s3_pz_ff[32], s3_pz_ff} + 34'sd2048;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_lane_ff <= '0;
         s3_lane_ff <= '0;
         s4_lane_ff <= '0;
      end else if (adv) begin
         s2_lane_ff <= lane_in;
         s3_lane_ff <= s2_lane_ff;
         s4_lane_ff <= s3_lane_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_slot_ff   <= slot_in;
         s2_vely_ff   <= vely_in;
         s2_age_ff    <= age_in;

         s3_slot_ff   <= s2_slot_ff;
         s3_vely_ff   <= s2_vely_ff;
         s3_age_ff    <= s2_age_ff;
         s3_retire_ff <= s2_age_ff > tick.plife;
         s3_px_ff     <= s2_slot_ff.vel_x * dt_s;
         s3_py_ff     <= s2_vely_ff * dt_s;
         s3_pz_ff     <= s2_slot_ff.vel_z * dt_s;

         s4_slot_ff   <= s3_slot_ff;
         s4_vely_ff   <= s3_vely_ff;
         s4_age_ff    <= s3_age_ff;
         s4_retire_ff <= s3_retire_ff;
         s4_sx_ff     <= rx[33:12];
         s4_sy_ff     <= ry[33:12];
         s4_sz_ff     <= rz[33:12];
      end
   end

   assign nx = pos_step(s4_slot_ff.pos_x, s4_sx_ff);
   assign ny = pos_step(s4_slot_ff.pos_y, s4_sy_ff);
   assign nz = pos_step(s4_slot_ff.pos_z, s4_sz_ff);

   always_comb begin
      stage_out.lane           = s4_lane_ff;
      stage_out.retire         = s4_retire_ff;
      stage_out.old_slot       = s4_slot_ff;
      stage_out.new_slot       = s4_slot_ff;
      stage_out.new_slot.pos_x = nx;
      stage_out.new_slot.pos_y = ny;
      stage_out.new_slot.pos_z = nz;
      stage_out.new_slot.vel_y = s4_vely_ff;
      stage_out.new_slot.age   = s4_age_ff;
   end

endmodule

FILE: src/ppt_checker.sv
// Port-level checks for particle_pool_tick_update, bound to the top level.
// Uses ppt_pkg.
module ppt_checker
   import ppt_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [SLOT_W-1:0]          rsp_slot_index,
   input logic                       rsp_slot_live,
   input logic signed [POS_W-1:0]    rsp_out_x,
   input logic signed [POS_W-1:0]    rsp_out_y,
   input logic signed [POS_W-1:0]    rsp_out_z,
   input logic                       rsp_emitter_alive,
   input logic                       rsp_last_of_tick
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_index)
         && $stable(rsp_slot_live) && $stable(rsp_out_x) && $stable(rsp_out_y)
         && $stable(rsp_out_z) && $stable(rsp_emitter_alive)
         && $stable(rsp_last_of_tick))
      else $error("result word changed while stalled");

   // a free slot reports the origin
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_slot_live |-> rsp_out_x == '0 && rsp_out_y == '0
         && rsp_out_z == '0)
      else $error("free slot reports a position");

   // mid-tick, no new request is taken
   a_busy_mid_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_tick |-> !req_ready)
      else $error("request ready before the tick finished");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind particle_pool_tick_update ppt_checker u_ppt_checker (.*);

FILE: tb/testbench.sv
// Testbench of particle_pool_tick_update: directed and random tick words, checked
// word by word against an in-file model of the slot pool and emitter.
// Depends on ppt_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench
   import ppt_pkg::*;
();

   localparam int     NSLOTS      = 64;
   localparam int     CYCLE_LIMIT = 1000000;
   localparam int     SETTLE      = 80;
   localparam longint POS_HI      = 8388607;
   localparam longint POS_LO      = -8388608;
   localparam int     AGE_TOP     = 1048575;

   typedef struct {
      logic                       op;
      logic [DT_W-1:0]            dt;
      logic                       spawn;
      logic signed [LAUNCH_W-1:0] lx;
      logic signed [LAUNCH_W-1:0] ly;
      logic signed [LAUNCH_W-1:0] lz;
   } tick_word_type;

   typedef struct {
      logic [SLOT_W-1:0]       idx;
      logic                    live;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic                    alive;
      logic                    last;
   } slot_report_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_operation = 1'b0;
   logic [DT_W-1:0]            req_delta_time = '0;
   logic                       req_spawn_request = 1'b0;
   logic signed [LAUNCH_W-1:0] req_launch_x = '0;
   logic signed [LAUNCH_W-1:0] req_launch_y = '0;
   logic signed [LAUNCH_W-1:0] req_launch_z = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [SLOT_W-1:0]          rsp_slot_index;
   logic                       rsp_slot_live;
   logic signed [POS_W-1:0]    rsp_out_x;
   logic signed [POS_W-1:0]    rsp_out_y;
   logic signed [POS_W-1:0]    rsp_out_z;
   logic                       rsp_emitter_alive;
   logic                       rsp_last_of_tick;
   logic                       csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   particle_pool_tick_update dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_delta_time    (req_delta_time),
      .req_spawn_request (req_spawn_request),
      .req_launch_x      (req_launch_x),
      .req_launch_y      (req_launch_y),
      .req_launch_z      (req_launch_z),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_slot_live     (rsp_slot_live),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_z         (rsp_out_z),
      .rsp_emitter_alive (rsp_emitter_alive),
      .rsp_last_of_tick  (rsp_last_of_tick),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // model copy of configuration
   logic signed [POS_W-1:0] spawn_x, spawn_y, spawn_z;
   logic [COUNT_W-1:0]      pool_count;
   logic [AGE_W-1:0]        emit_life, part_life;
   logic [1:0]              motion;

   // model copy of the pool
   logic                    live_m [NSLOTS];
   logic signed [POS_W-1:0] px [NSLOTS], py [NSLOTS], pz [NSLOTS];
   logic signed [VEL_W-1:0] vx [NSLOTS], vy [NSLOTS], vz [NSLOTS];
   logic [AGE_W-1:0]        sage [NSLOTS];
   logic [AGE_W-1:0]        em_age;

   tick_word_type   tick_q [$];
   slot_report_type report_q [$];
   tick_word_type   cur_word;
   int              pushed_total = 0;
   int              accepted_total = 0;
   int              errors = 0;
   int              cycle_count = 0;
   int              send_gap = 0;
   int              ready_gap = 0;
   bit              calm = 1'b0;
   bit              fire;

   function automatic logic [AGE_W-1:0] age_sum(input logic [AGE_W-1:0] a,
                                                input logic [DT_W-1:0] d);
      int s;
      s = int'(a) + int'(d);
      return (s > AGE_TOP) ? AGE_W'(AGE_TOP) : AGE_W'(s);
   endfunction

   function automatic logic signed [VEL_W-1:0] vel_bias(input logic signed [VEL_W-1:0] v,
                                                        input int b);
      int s;
      s = int'(v) + b;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return VEL_W'(s);
   endfunction

   // step is vel*dt/4096 rounded half up, then a saturating add
   function automatic logic signed [POS_W-1:0] moved(input logic signed [POS_W-1:0] pos,
                                                     input logic signed [VEL_W-1:0] vel,
                                                     input logic [DT_W-1:0] dt);
      longint p, step, s;
      p    = longint'(vel) * longint'({1'b0, dt});
      step = (p + 64'sd2048) >>> 12;
      s    = longint'(pos) + step;
      if (s > POS_HI) s = POS_HI;
      if (s < POS_LO) s = POS_LO;
      return POS_W'(s);
   endfunction

   function automatic logic signed [VEL_W-1:0] launch_speed(input logic signed [LAUNCH_W-1:0] raw);
      int v;
      v = raw;
      if (v > MAX_SPEED - 1) v = MAX_SPEED - 1;
      if (v < -(MAX_SPEED - 1)) v = -(MAX_SPEED - 1);
      return VEL_W'(v * 256);
   endfunction

   task automatic advance_pool(input tick_word_type w);
      int              n;
      logic            alive;
      bit              placed;
      slot_report_type r;
      n = (pool_count > NSLOTS) ? NSLOTS : int'(pool_count);
      if (w.op == OP_RESTART) begin
         em_age = '0;
      end else begin
         em_age = age_sum(em_age, w.dt);
         for (int i = 0; i < n; i++) begin
            if (live_m[i]) begin
               if (motion == MODE_WATER) begin
                  vy[i] = vel_bias(vy[i], -MODE_BIAS);
               end else if (motion == MODE_SMOKE) begin
                  vy[i] = vel_bias(vy[i], MODE_BIAS);
               end
               sage[i] = age_sum(sage[i], w.dt);
               px[i] = moved(px[i], vx[i], w.dt);
               py[i] = moved(py[i], vy[i], w.dt);
               pz[i] = moved(pz[i], vz[i], w.dt);
               // retired particles still moved this tick
               if (sage[i] > part_life) live_m[i] = 1'b0;
            end
         end
         if (w.spawn) begin
            placed = 1'b0;
            for (int i = 0; i < n; i++) begin
               if (!placed && !live_m[i]) begin
                  px[i] = spawn_x;
                  py[i] = spawn_y;
                  pz[i] = spawn_z;
                  vx[i] = launch_speed(w.lx);
                  vy[i] = launch_speed(w.ly);
                  vz[i] = launch_speed(w.lz);
                  sage[i] = '0;
                  live_m[i] = 1'b1;
                  placed = 1'b1;
               end
            end
         end
      end
      alive = (em_age <= emit_life);
      for (int i = 0; i < n; i++) begin
         r.idx   = SLOT_W'(i);
         r.live  = live_m[i];
         r.x     = live_m[i] ? px[i] : '0;
         r.y     = live_m[i] ? py[i] : '0;
         r.z     = live_m[i] ? pz[i] : '0;
         r.alive = alive;
         r.last  = (i + 1 == n);
         report_q.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic queue_tick(input logic op, input int dt, input logic spawn,
                             input int lx, input int ly, input int lz);
      tick_word_type w;
      w.op    = op;
      w.dt    = DT_W'(dt);
      w.spawn = spawn;
      w.lx    = LAUNCH_W'(lx);
      w.ly    = LAUNCH_W'(ly);
      w.lz    = LAUNCH_W'(lz);
      tick_q.push_back(w);
      pushed_total++;
   endtask

   // one register write per edge; end_writes drops the enable
   task automatic program_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'(val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         REG_EMITTER_X:     spawn_x = v;
         REG_EMITTER_Y:     spawn_y = v;
         REG_EMITTER_Z:     spawn_z = v;
         REG_ACTIVE_COUNT: begin
            pool_count = v[COUNT_W-1:0];
            for (int i = int'(v[COUNT_W-1:0]); i < NSLOTS; i++) live_m[i] = 1'b0;
         end
         REG_EMITTER_LIFE:  emit_life = v[AGE_W-1:0];
         REG_PARTICLE_LIFE: part_life = v[AGE_W-1:0];
         REG_MOTION_MODE:   motion = v[1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sender holds off until every word is taken and every report is back
   task automatic drain();
      while (!(accepted_total == pushed_total && report_q.size() == 0)) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            advance_pool(cur_word);
            accepted_total++;
         end
         if (!req_valid || fire) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 13) - 1;
               req_valid <= 1'b0;
            end else if (tick_q.size() != 0) begin
               cur_word = tick_q.pop_front();
               req_operation     <= cur_word.op;
               req_delta_time    <= cur_word.dt;
               req_spawn_request <= cur_word.spawn;
               req_launch_x      <= cur_word.lx;
               req_launch_y      <= cur_word.ly;
               req_launch_z      <= cur_word.lz;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (report_q.size() == 0) begin
               $display("%0t unexpected word slot %0d", $time, rsp_slot_index);
               errors++;
            end else begin
               check_field("slot_index", report_q[0].idx, rsp_slot_index);
               check_field("slot_live", report_q[0].live, rsp_slot_live);
               check_field("out_x", report_q[0].x, rsp_out_x);
               check_field("out_y", report_q[0].y, rsp_out_y);
               check_field("out_z", report_q[0].z, rsp_out_z);
               check_field("emitter_alive", report_q[0].alive, rsp_emitter_alive);
               check_field("last_of_tick", report_q[0].last, rsp_last_of_tick);
               void'(report_q.pop_front());
            end
         end
         if (ready_gap != 0) begin
            ready_gap--;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            ready_gap = $urandom_range(1, 13);
         end
         rsp_ready <= (ready_gap == 0);
      end
   end

   initial begin
      int pick;
      int cnt_v;
      int roll;
      int dt_v;
      int pos_v;

      spawn_x = '0; spawn_y = '0; spawn_z = '0;
      pool_count = COUNT_W'(1);
      emit_life = '0; part_life = '0; motion = MODE_SPARK;
      em_age = '0;
      for (int i = 0; i < NSLOTS; i++) begin
         live_m[i] = 1'b0;
         px[i] = '0; py[i] = '0; pz[i] = '0;
         vx[i] = '0; vy[i] = '0; vz[i] = '0;
         sage[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one slot, zero lifetimes
      queue_tick(OP_TICK, 0, 1'b1, 15, -15, 0);
      queue_tick(OP_TICK, 1, 1'b0, 0, 0, 0);      // age passes zero life: retires
      queue_tick(OP_RESTART, 65535, 1'b1, -1, 1, -15);
      drain();

      // small pool, water, fill it and overflow the spawn
      program_reg(REG_EMITTER_X, 100);
      program_reg(REG_EMITTER_Y, -200);
      program_reg(REG_EMITTER_Z, 300);
      program_reg(REG_ACTIVE_COUNT, 4);
      program_reg(REG_EMITTER_LIFE, 5000);
      program_reg(REG_PARTICLE_LIFE, 30000);
      program_reg(REG_MOTION_MODE, MODE_WATER);
      end_writes();
      queue_tick(OP_TICK, 100, 1'b1, 15, 15, 15);
      queue_tick(OP_TICK, 200, 1'b1, -15, -15, -15);
      queue_tick(OP_TICK, 300, 1'b1, 1, -1, 0);
      queue_tick(OP_TICK, 400, 1'b1, 0, 0, 0);
      queue_tick(OP_TICK, 500, 1'b1, -2, 2, 7);   // pool full, no spawn
      queue_tick(OP_TICK, 4096, 1'b0, 0, 0, 0);
      queue_tick(OP_TICK, 65535, 1'b1, 3, 3, 3);  // emitter already dead; particles retire, slot 0 respawns
      queue_tick(OP_RESTART, 12345, 1'b0, 0, 0, 0);
      queue_tick(OP_TICK, 0, 1'b0, 0, 0, 0);
      drain();

      // full pool at the position extremes, smoke, saturating moves
      program_reg(REG_EMITTER_X, 32'h007FFFFF);
      program_reg(REG_EMITTER_Y, 32'h00800000);
      program_reg(REG_EMITTER_Z, 32'h007FFFFF);
      program_reg(REG_ACTIVE_COUNT, 64);
      program_reg(REG_EMITTER_LIFE, AGE_TOP);
      program_reg(REG_PARTICLE_LIFE, AGE_TOP);
      program_reg(REG_MOTION_MODE, MODE_SMOKE);
      end_writes();
      repeat (4) queue_tick(OP_TICK, 65535, 1'b1, 15, -15, 15);
      queue_tick(OP_TICK, 65535, 1'b1, -15, 15, -15);
      drain();

      // shrinking frees the upper slots
      program_reg(REG_ACTIVE_COUNT, 2);
      end_writes();
      queue_tick(OP_TICK, 100, 1'b1, 1, 1, 1);
      queue_tick(OP_TICK, 100, 1'b1, 1, 1, 1);
      drain();

      // empty pool: no reports at all
      program_reg(REG_ACTIVE_COUNT, 0);
      end_writes();
      queue_tick(OP_TICK, 50, 1'b1, 1, 1, 1);
      queue_tick(OP_RESTART, 50, 1'b0, 0, 0, 0);
      drain();

      // count above the pool, unused mode, zero particle life
      program_reg(REG_ACTIVE_COUNT, 100);
      program_reg(REG_MOTION_MODE, 3);
      program_reg(REG_PARTICLE_LIFE, 0);
      program_reg(REG_EMITTER_LIFE, 0);
      end_writes();
      queue_tick(OP_TICK, 0, 1'b1, 5, -5, 1);
      queue_tick(OP_TICK, 10, 1'b1, -1, 0, 1);
      queue_tick(OP_RESTART, 0, 1'b0, 0, 0, 0);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) cnt_v = $urandom_range(1, 8);
         else if (pick < 15) cnt_v = 64;
         else cnt_v = $urandom_range(0, 127);
         pos_v = ($urandom_range(0, 3) == 0) ? 32'h007FFFFF : $urandom;
         program_reg(REG_EMITTER_X, pos_v);
         pos_v = ($urandom_range(0, 3) == 0) ? 32'h00800000 : $urandom;
         program_reg(REG_EMITTER_Y, pos_v);
         pos_v = $urandom;
         program_reg(REG_EMITTER_Z, pos_v);
         program_reg(REG_ACTIVE_COUNT, cnt_v);
         program_reg(REG_EMITTER_LIFE,
                     ($urandom_range(0, 3) == 0) ? AGE_TOP : $urandom_range(0, 30000));
         pick = $urandom_range(0, 3);
         program_reg(REG_PARTICLE_LIFE,
                     (pick == 0) ? 0 : (pick == 1) ? AGE_TOP : $urandom_range(0, 6000));
         program_reg(REG_MOTION_MODE, $urandom_range(0, 3));
         end_writes();
         calm = (ph == 8);
         for (int k = 0; k < 16; k++) begin
            roll = $urandom_range(0, 9);
            if (roll < 7) dt_v = $urandom_range(0, 1023);
            else if (roll == 7) dt_v = 0;
            else dt_v = $urandom_range(0, 65535);
            queue_tick(($urandom_range(0, 11) == 0) ? OP_RESTART : OP_TICK, dt_v,
                       ($urandom_range(0, 3) != 0),
                       $urandom_range(0, 30) - 15, $urandom_range(0, 30) - 15,
                       $urandom_range(0, 30) - 15);
         end
         drain();
      end

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
src/ppt_pkg.sv
src/ppt_ram.sv
src/ppt_slot_pipe.sv
src/particle_pool_tick_update.sv
src/ppt_checker.sv
tb/testbench.sv
